>>> hdl/clrs_pkg.sv
// Shared types and constants for the character LCD refresh sequencer.
package clrs_pkg;

  localparam int LINE_CHARS  = 16;
  localparam int TOTAL_CHARS = 32;

  localparam int SLOT_W = 5;
  localparam int IDX_W  = $clog2(TOTAL_CHARS);
  localparam int POS_W  = $clog2(TOTAL_CHARS + 1);
  localparam int CT_W   = $clog2(LINE_CHARS + 1);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_CTL  = 8'h0C;
  localparam logic [7:0] DDRAM_LINE0   = 8'h80;
  localparam logic [7:0] DDRAM_LINE1   = 8'hC0;
  localparam logic [3:0] NIB_RESET     = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;
  localparam logic [7:0] SPACE_CHAR    = 8'h20;
  localparam logic [1:0] RESET_REPEATS = 2'd3;

  localparam logic [7:0] POWER_UP_WAIT_RST      = 8'd35;
  localparam logic [7:0] RESET_NIBBLE_WAIT_RST  = 8'd5;
  localparam logic [7:0] LONG_COMMAND_WAIT_RST  = 8'd2;
  localparam logic [7:0] SHORT_COMMAND_WAIT_RST = 8'd1;

  typedef enum logic [1:0] {
    CFG_POWER_UP_WAIT,
    CFG_RESET_NIBBLE_WAIT,
    CFG_LONG_COMMAND_WAIT,
    CFG_SHORT_COMMAND_WAIT
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] char_slot;
    logic [7:0]        char_code;
  } item_t;

  typedef struct packed {
    logic       register_select;
    logic       enable_strobe;
    logic [3:0] data_nibble;
    logic       backlight_on;
    logic       rw_pin;
  } result_t;

endpackage

>>> hdl/clrs_char_buf.sv
// Display character buffer: one write port, one combinational read port.
module clrs_char_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [clrs_pkg::SLOT_W-1:0] wr_slot,
  input  logic [7:0]                wr_code,
  input  logic [clrs_pkg::IDX_W-1:0]  rd_idx,
  output logic [7:0]                rd_code
);
  import clrs_pkg::*;

  logic [7:0] chars [TOTAL_CHARS];

  // Reset fills the buffer with blanks; drop writes beyond the last slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_CHARS; i++) begin
        chars[i] <= SPACE_CHAR;
      end
    end else if (wr_en && (32'(wr_slot) < 32'(TOTAL_CHARS))) begin
      chars[IDX_W'(wr_slot)] <= wr_code;
    end
  end

  assign rd_code = chars[rd_idx];

endmodule

>>> hdl/char_lcd_refresh_sequencer.sv
// Top level of the character LCD refresh sequencer for a 4-bit bus.
module char_lcd_refresh_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  clrs_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output clrs_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clrs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [clrs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [clrs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);
  // Drives a 2x16 character LCD over a 4-bit bus (RS, E, D4..D7, RW,
  // backlight). Each input transaction is either a time tick, which
  // advances the phase machine by one step, or a character write into the
  // 32-entry display buffer, which leaves the pins alone. Every input
  // transaction yields exactly one output transaction carrying the pin
  // levels after it was handled. After a power-up wait of power_up_wait
  // ticks the sequencer turns on the backlight, raises RW, clears the
  // display, sends four 0x3 reset nibbles (E held for reset_nibble_wait
  // ticks each) and one 0x2 nibble, then return home, function set 0x28 and
  // display control 0x0C. It then refreshes the display forever, sending
  // each buffer character high nibble first with RS high and setting the
  // cursor to 0xC0 after the first line and back to 0x80 after the last.
  // The wait registers sit at byte addresses 0, 4, 8 and 12 of the APB
  // port and should only be written while no transaction is in flight; a
  // wait of zero behaves like one. Throughput is one transaction per clock:
  // each step is a single phase transition computed between the state
  // registers and the result register, and the input stalls only while a
  // finished result sits in the result register with its receiver stalled.
  // The buffer lives in flip-flops that reset fills with spaces, so no
  // clearing pass follows reset.
  import clrs_pkg::*;

  typedef enum logic [4:0] {
    PH_STOP    = 5'd0,
    PH_START   = 5'd1,
    PH_INIT    = 5'd2,
    PH_FSET_HI = 5'd3,
    PH_FSET_LO = 5'd4,
    PH_DCTL_HI = 5'd5,
    PH_DCTL_LO = 5'd6,
    PH_CHAR_HI = 5'd7,
    PH_CHAR_LO = 5'd8,
    PH_CURS_HI = 5'd9,
    PH_CURS_LO = 5'd10,
    PH_CLR_HI  = 5'd11,
    PH_CLR_LO  = 5'd12,
    PH_HOME_HI = 5'd13,
    PH_HOME_LO = 5'd14,
    PH_RST_A   = 5'd15,
    PH_RST_B   = 5'd16,
    PH_E_OFF   = 5'd17,
    PH_WAIT    = 5'd18
  } phase_t;

  // Wait registers.
  logic [7:0] power_up_wait;
  logic [7:0] reset_nibble_wait;
  logic [7:0] long_command_wait;
  logic [7:0] short_command_wait;

  // Sequencer state and next values.
  phase_t            phase, phase_next;
  phase_t            return_phase, return_phase_next;
  phase_t            saved_return_phase, saved_return_phase_next;
  logic [7:0]        wait_count, wait_count_next;
  logic [POS_W-1:0]  char_position, char_position_next;
  logic [CT_W-1:0]   cursor_target, cursor_target_next;
  logic              on_second_line, on_second_line_next;
  logic [7:0]        byte_latch, byte_latch_next;
  logic [1:0]        reset_repeats_left, reset_repeats_left_next;
  result_t           pins, pins_next;

  logic       item_accept;
  logic       tick;
  logic [7:0] buf_code;
  logic [7:0] cursor_byte;
  cfg_reg_t   cfg_sel;
  logic       cfg_write;

  // ---------------------------------------------------------------------
  // Handshake: take a new transaction unless the result register is full
  // and its receiver is stalling.
  // ---------------------------------------------------------------------
  assign item_stall  = result_valid && result_stall;
  assign item_accept = item_valid && !item_stall;
  assign tick        = item_accept && !item.kind;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_up_wait      <= POWER_UP_WAIT_RST;
      reset_nibble_wait  <= RESET_NIBBLE_WAIT_RST;
      long_command_wait  <= LONG_COMMAND_WAIT_RST;
      short_command_wait <= SHORT_COMMAND_WAIT_RST;
    end else if (cfg_write) begin
      case (cfg_sel)
        CFG_POWER_UP_WAIT:      power_up_wait      <= pwdata[7:0];
        CFG_RESET_NIBBLE_WAIT:  reset_nibble_wait  <= pwdata[7:0];
        CFG_LONG_COMMAND_WAIT:  long_command_wait  <= pwdata[7:0];
        CFG_SHORT_COMMAND_WAIT: short_command_wait <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CFG_POWER_UP_WAIT:      prdata = CFG_DATA_W'(power_up_wait);
      CFG_RESET_NIBBLE_WAIT:  prdata = CFG_DATA_W'(reset_nibble_wait);
      CFG_LONG_COMMAND_WAIT:  prdata = CFG_DATA_W'(long_command_wait);
      CFG_SHORT_COMMAND_WAIT: prdata = CFG_DATA_W'(short_command_wait);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Character buffer: written by buffer transactions, read at the refresh
  // position.
  // ---------------------------------------------------------------------
  clrs_char_buf u_char_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (item_accept && item.kind),
    .wr_slot (item.char_slot),
    .wr_code (item.char_code),
    .rd_idx  (char_position[IDX_W-1:0]),
    .rd_code (buf_code)
  );

  // Cursor address for the line the refresh is about to enter.
  always_comb begin
    if (32'(cursor_target) < 32'(LINE_CHARS)) begin
      cursor_byte = DDRAM_LINE0 + 8'(cursor_target);
    end else begin
      cursor_byte = DDRAM_LINE1 + (8'(cursor_target) - 8'(LINE_CHARS));
    end
  end

  // ---------------------------------------------------------------------
  // Phase machine: one step per tick. A "high" phase puts out the upper
  // nibble, raises E and drops it on the next tick; a "low" phase puts out
  // the lower nibble and holds E through the wait count.
  // ---------------------------------------------------------------------
  always_comb begin
    phase_next              = phase;
    return_phase_next       = return_phase;
    saved_return_phase_next = saved_return_phase;
    wait_count_next         = wait_count;
    char_position_next      = char_position;
    cursor_target_next      = cursor_target;
    on_second_line_next     = on_second_line;
    byte_latch_next         = byte_latch;
    reset_repeats_left_next = reset_repeats_left;
    pins_next               = pins;

    if (tick) begin
      case (phase)
        PH_START: begin
          return_phase_next = PH_INIT;
          phase_next        = PH_WAIT;
          wait_count_next   = power_up_wait;
        end
        PH_INIT: begin
          pins_next.data_nibble     = 4'h0;
          pins_next.enable_strobe   = 1'b0;
          pins_next.register_select = 1'b0;
          pins_next.backlight_on    = 1'b1;
          pins_next.rw_pin          = 1'b1;
          return_phase_next         = PH_RST_A;
          phase_next                = PH_CLR_HI;
        end
        PH_RST_A: begin
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = NIB_RESET;
          pins_next.enable_strobe   = 1'b1;
          // Count down the reset nibbles; stop at zero.
          if (reset_repeats_left == 2'd0) begin
            return_phase_next = PH_RST_B;
          end else begin
            return_phase_next       = PH_RST_A;
            reset_repeats_left_next = reset_repeats_left - 2'd1;
          end
          phase_next      = PH_WAIT;
          wait_count_next = reset_nibble_wait;
        end
        PH_RST_B: begin
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = NIB_4BIT;
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_HOME_HI;
          phase_next                = PH_E_OFF;
        end
        PH_HOME_HI: begin
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = CMD_HOME[7:4];
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_HOME_LO;
          phase_next                = PH_E_OFF;
        end
        PH_HOME_LO: begin
          pins_next.data_nibble   = CMD_HOME[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = PH_FSET_HI;
          phase_next              = PH_WAIT;
          wait_count_next         = long_command_wait;
        end
        PH_FSET_HI: begin
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = CMD_FUNC_SET[7:4];
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_FSET_LO;
          phase_next                = PH_E_OFF;
        end
        PH_FSET_LO: begin
          pins_next.data_nibble   = CMD_FUNC_SET[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = PH_DCTL_HI;
          phase_next              = PH_WAIT;
          wait_count_next         = short_command_wait;
        end
        PH_DCTL_HI: begin
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = CMD_DISP_CTL[7:4];
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_DCTL_LO;
          phase_next                = PH_E_OFF;
        end
        PH_DCTL_LO: begin
          pins_next.data_nibble   = CMD_DISP_CTL[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = PH_CHAR_HI;
          phase_next              = PH_WAIT;
          wait_count_next         = short_command_wait;
        end
        PH_CHAR_HI: begin
          pins_next.register_select = 1'b1;
          if ((char_position >= POS_W'(LINE_CHARS)) && !on_second_line) begin
            // End of the first line: move the cursor to the second line.
            cursor_target_next = CT_W'(LINE_CHARS);
            phase_next         = PH_CURS_HI;
          end else if (char_position >= POS_W'(TOTAL_CHARS)) begin
            // End of the buffer: wrap back to the top left.
            return_phase_next  = PH_CHAR_HI;
            phase_next         = PH_CURS_HI;
            char_position_next = '0;
            cursor_target_next = '0;
          end else begin
            byte_latch_next         = buf_code;
            char_position_next      = char_position + POS_W'(1);
            pins_next.data_nibble   = buf_code[7:4];
            pins_next.enable_strobe = 1'b1;
            return_phase_next       = PH_CHAR_LO;
            phase_next              = PH_E_OFF;
          end
        end
        PH_CHAR_LO: begin
          pins_next.data_nibble   = byte_latch[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = PH_CHAR_HI;
          phase_next              = PH_WAIT;
          wait_count_next         = short_command_wait;
        end
        PH_WAIT: begin
          if (wait_count <= 8'd1) begin
            wait_count_next = 8'd0;
            phase_next      = PH_E_OFF;
          end else begin
            wait_count_next = wait_count - 8'd1;
          end
        end
        PH_CLR_HI: begin
          char_position_next        = '0;
          saved_return_phase_next   = return_phase;
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = CMD_CLEAR[7:4];
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_CLR_LO;
          phase_next                = PH_E_OFF;
        end
        PH_CLR_LO: begin
          pins_next.data_nibble   = CMD_CLEAR[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = saved_return_phase;
          phase_next              = PH_WAIT;
          wait_count_next         = long_command_wait;
        end
        PH_E_OFF: begin
          pins_next.enable_strobe = 1'b0;
          phase_next              = return_phase;
        end
        PH_CURS_HI: begin
          byte_latch_next           = cursor_byte;
          on_second_line_next       = !(32'(cursor_target) < 32'(LINE_CHARS));
          pins_next.register_select = 1'b0;
          pins_next.data_nibble     = cursor_byte[7:4];
          pins_next.enable_strobe   = 1'b1;
          return_phase_next         = PH_CURS_LO;
          phase_next                = PH_E_OFF;
        end
        PH_CURS_LO: begin
          pins_next.data_nibble   = byte_latch[3:0];
          pins_next.enable_strobe = 1'b1;
          return_phase_next       = PH_CHAR_HI;
          phase_next              = PH_WAIT;
          wait_count_next         = long_command_wait;
        end
        default: ;  // stop phase: hold everything
      endcase
    end
  end

  // State registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_START;
      return_phase       <= PH_STOP;
      saved_return_phase <= PH_STOP;
      wait_count         <= '0;
      char_position      <= '0;
      cursor_target      <= '0;
      on_second_line     <= 1'b0;
      byte_latch         <= '0;
      reset_repeats_left <= RESET_REPEATS;
      pins               <= '0;
      result_valid       <= 1'b0;
    end else begin
      phase              <= phase_next;
      return_phase       <= return_phase_next;
      saved_return_phase <= saved_return_phase_next;
      wait_count         <= wait_count_next;
      char_position      <= char_position_next;
      cursor_target      <= cursor_target_next;
      on_second_line     <= on_second_line_next;
      byte_latch         <= byte_latch_next;
      reset_repeats_left <= reset_repeats_left_next;
      pins               <= pins_next;
      if (item_accept) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    // Load the pin levels after this transaction into the result register.
    if (item_accept) begin
      result <= pins_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("input taken while result register is full and stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted transaction produced no result");

  a_backlight_sticks: assert property (@(posedge clk) disable iff (rst)
    pins.backlight_on |=> pins.backlight_on)
    else $error("backlight dropped after initialization");

  a_rw_with_backlight: assert property (@(posedge clk) disable iff (rst)
    pins.backlight_on == pins.rw_pin)
    else $error("RW and backlight pins out of step");

endmodule

>>> tb/char_lcd_refresh_sequencer_tb.sv
// Self-checking testbench for the character LCD refresh sequencer.
module char_lcd_refresh_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clrs_pkg::*;

  // Phase codes of the shadow sequencer, mirroring the block's phase machine.
  typedef enum logic [4:0] {
    SEQ_STOP    = 5'd0,
    SEQ_START   = 5'd1,
    SEQ_INIT    = 5'd2,
    SEQ_FSET_HI = 5'd3,
    SEQ_FSET_LO = 5'd4,
    SEQ_DCTL_HI = 5'd5,
    SEQ_DCTL_LO = 5'd6,
    SEQ_CHAR_HI = 5'd7,
    SEQ_CHAR_LO = 5'd8,
    SEQ_CURS_HI = 5'd9,
    SEQ_CURS_LO = 5'd10,
    SEQ_CLR_HI  = 5'd11,
    SEQ_CLR_LO  = 5'd12,
    SEQ_HOME_HI = 5'd13,
    SEQ_HOME_LO = 5'd14,
    SEQ_RST_A   = 5'd15,
    SEQ_RST_B   = 5'd16,
    SEQ_E_OFF   = 5'd17,
    SEQ_WAIT    = 5'd18
  } seq_phase_t;

  localparam int KIND_TICK  = 0;
  localparam int KIND_WRITE = 1;

  // DUT connections; every input starts at a known level.
  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_stall;
  item_t                 item         = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel         = 1'b0;
  logic                  penable      = 1'b0;
  logic                  pwrite       = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr        = '0;
  logic [CFG_DATA_W-1:0] pwdata       = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  char_lcd_refresh_sequencer u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns clock: low half, then high half.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the sequencer state and its wait registers.
  seq_phase_t seq_phase, ret_phase, saved_ret_phase;
  logic [8:0] wait_cnt;
  int         char_pos;
  int         cursor_tgt;
  logic       second_line;
  logic [7:0] byte_latch;
  int         repeats_left;
  logic [7:0] shadow_chars [TOTAL_CHARS];
  result_t    pins;
  logic [7:0] cfg_power_up, cfg_rst_nibble, cfg_long_wait, cfg_short_wait;

  // Transaction bookkeeping.
  item_t   pending_items [$];
  result_t expected_pins [$];
  item_t   next_item;
  result_t want_pins;
  int      gap_pct  = 27;
  int      hold_pct = 27;
  int      errors   = 0;
  int      n_ticks  = 0;
  int      n_writes = 0;
  int      n_checked = 0;

  function automatic void seq_reset();
    cfg_power_up    = POWER_UP_WAIT_RST;
    cfg_rst_nibble  = RESET_NIBBLE_WAIT_RST;
    cfg_long_wait   = LONG_COMMAND_WAIT_RST;
    cfg_short_wait  = SHORT_COMMAND_WAIT_RST;
    seq_phase       = SEQ_START;
    ret_phase       = SEQ_STOP;
    saved_ret_phase = SEQ_STOP;
    wait_cnt        = '0;
    char_pos        = 0;
    cursor_tgt      = 0;
    second_line     = 1'b0;
    byte_latch      = '0;
    repeats_left    = int'(RESET_REPEATS);
    pins            = '0;
    foreach (shadow_chars[i]) shadow_chars[i] = SPACE_CHAR;
  endfunction

  // Raise E with the high nibble, then drop E on the following tick.
  function automatic void strobe_high(logic rs, logic [7:0] b, seq_phase_t nxt);
    pins.register_select = rs;
    pins.data_nibble     = b[7:4];
    pins.enable_strobe   = 1'b1;
    ret_phase            = nxt;
    seq_phase            = SEQ_E_OFF;
  endfunction

  // Raise E with the low nibble, then hold for the given wait.
  function automatic void strobe_low(logic [7:0] b, seq_phase_t nxt, logic [7:0] w);
    pins.data_nibble   = b[3:0];
    pins.enable_strobe = 1'b1;
    ret_phase          = nxt;
    seq_phase          = SEQ_WAIT;
    wait_cnt           = {1'b0, w};
  endfunction

  function automatic void seq_tick();
    case (seq_phase)
      SEQ_START: begin
        ret_phase = SEQ_INIT;
        seq_phase = SEQ_WAIT;
        wait_cnt  = {1'b0, cfg_power_up};
      end
      SEQ_INIT: begin
        pins.data_nibble     = 4'h0;
        pins.enable_strobe   = 1'b0;
        pins.register_select = 1'b0;
        pins.backlight_on    = 1'b1;
        pins.rw_pin          = 1'b1;
        ret_phase            = SEQ_RST_A;
        seq_phase            = SEQ_CLR_HI;
      end
      SEQ_RST_A: begin
        pins.register_select = 1'b0;
        pins.data_nibble     = NIB_RESET;
        pins.enable_strobe   = 1'b1;
        if (repeats_left == 0) begin
          ret_phase = SEQ_RST_B;
        end else begin
          ret_phase    = SEQ_RST_A;
          repeats_left = repeats_left - 1;
        end
        seq_phase = SEQ_WAIT;
        wait_cnt  = {1'b0, cfg_rst_nibble};
      end
      SEQ_RST_B: begin
        pins.register_select = 1'b0;
        pins.data_nibble     = NIB_4BIT;
        pins.enable_strobe   = 1'b1;
        ret_phase            = SEQ_HOME_HI;
        seq_phase            = SEQ_E_OFF;
      end
      SEQ_HOME_HI: strobe_high(1'b0, CMD_HOME, SEQ_HOME_LO);
      SEQ_HOME_LO: strobe_low(CMD_HOME, SEQ_FSET_HI, cfg_long_wait);
      SEQ_FSET_HI: strobe_high(1'b0, CMD_FUNC_SET, SEQ_FSET_LO);
      SEQ_FSET_LO: strobe_low(CMD_FUNC_SET, SEQ_DCTL_HI, cfg_short_wait);
      SEQ_DCTL_HI: strobe_high(1'b0, CMD_DISP_CTL, SEQ_DCTL_LO);
      SEQ_DCTL_LO: strobe_low(CMD_DISP_CTL, SEQ_CHAR_HI, cfg_short_wait);
      SEQ_CHAR_HI: begin
        // RS goes high even on the ticks that only pick a cursor move.
        pins.register_select = 1'b1;
        if (char_pos >= LINE_CHARS && !second_line) begin
          cursor_tgt = LINE_CHARS;
          seq_phase  = SEQ_CURS_HI;
        end else if (char_pos >= TOTAL_CHARS) begin
          ret_phase  = SEQ_CHAR_HI;
          seq_phase  = SEQ_CURS_HI;
          char_pos   = 0;
          cursor_tgt = 0;
        end else begin
          byte_latch = shadow_chars[char_pos];
          char_pos   = char_pos + 1;
          strobe_high(1'b1, byte_latch, SEQ_CHAR_LO);
        end
      end
      SEQ_CHAR_LO: strobe_low(byte_latch, SEQ_CHAR_HI, cfg_short_wait);
      SEQ_WAIT: begin
        // A wait of zero ends just like a wait of one.
        if (wait_cnt <= 9'd1) begin
          wait_cnt  = '0;
          seq_phase = SEQ_E_OFF;
        end else begin
          wait_cnt = wait_cnt - 9'd1;
        end
      end
      SEQ_CLR_HI: begin
        char_pos        = 0;
        saved_ret_phase = ret_phase;
        strobe_high(1'b0, CMD_CLEAR, SEQ_CLR_LO);
      end
      SEQ_CLR_LO: strobe_low(CMD_CLEAR, saved_ret_phase, cfg_long_wait);
      SEQ_E_OFF: begin
        pins.enable_strobe = 1'b0;
        seq_phase          = ret_phase;
      end
      SEQ_CURS_HI: begin
        if (cursor_tgt < LINE_CHARS) begin
          byte_latch  = DDRAM_LINE0 + 8'(cursor_tgt);
          second_line = 1'b0;
        end else begin
          byte_latch  = DDRAM_LINE1 + 8'(cursor_tgt - LINE_CHARS);
          second_line = 1'b1;
        end
        strobe_high(1'b0, byte_latch, SEQ_CURS_LO);
      end
      SEQ_CURS_LO: strobe_low(byte_latch, SEQ_CHAR_HI, cfg_long_wait);
      default: ;
    endcase
  endfunction

  // Pin levels expected after one transaction on the item channel.
  function automatic result_t lcd_pins_after(item_t it);
    if (it.kind == 1'(KIND_WRITE)) begin
      // Buffer writes leave the pins and the phase machine alone.
      if (int'(it.char_slot) < TOTAL_CHARS) shadow_chars[it.char_slot] = it.char_code;
      n_writes++;
    end else begin
      seq_tick();
      n_ticks++;
    end
    return pins;
  endfunction

  // Driver: present queued items; hold the payload while stalled.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        next_item = pending_items.pop_front();
        // Items go in order and are never withdrawn, so predict on launch.
        expected_pins.push_back(lcd_pins_after(next_item));
        item       <= next_item;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pins.size() == 0) begin
          $error("unexpected result transaction: %p", result);
          errors++;
        end else begin
          want_pins = expected_pins.pop_front();
          n_checked++;
          if (result.register_select !== want_pins.register_select) begin
            $error("register_select: expected %0d, actual %0d",
                   want_pins.register_select, result.register_select);
            errors++;
          end
          if (result.enable_strobe !== want_pins.enable_strobe) begin
            $error("enable_strobe: expected %0d, actual %0d",
                   want_pins.enable_strobe, result.enable_strobe);
            errors++;
          end
          if (result.data_nibble !== want_pins.data_nibble) begin
            $error("data_nibble: expected %0h, actual %0h",
                   want_pins.data_nibble, result.data_nibble);
            errors++;
          end
          if (result.backlight_on !== want_pins.backlight_on) begin
            $error("backlight_on: expected %0d, actual %0d",
                   want_pins.backlight_on, result.backlight_on);
            errors++;
          end
          if (result.rw_pin !== want_pins.rw_pin) begin
            $error("rw_pin: expected %0d, actual %0d", want_pins.rw_pin, result.rw_pin);
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(0, 99) < hold_pct);
    end
  end

  function automatic void push_item(int kind, int slot, int code);
    item_t it;
    it.kind      = 1'(kind);
    it.char_slot = SLOT_W'(slot);
    it.char_code = 8'(code);
    pending_items.push_back(it);
  endfunction

  // Mostly ticks to keep the phase machine moving, with scattered buffer writes.
  function automatic void push_random(int count, int write_pct);
    for (int i = 0; i < count; i++) begin
      push_item(($urandom_range(0, 99) < write_pct) ? KIND_WRITE : KIND_TICK,
                $urandom_range(0, 31), $urandom_range(0, 255));
    end
  endfunction

  // Setup then access cycle; the register lands at the edge with penable high.
  task automatic cfg_write(cfg_reg_t r, logic [7:0] v);
    logic [23:0] upper;
    upper = 24'($urandom);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(r) * 4);
    pwdata  <= {upper, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      CFG_POWER_UP_WAIT:      cfg_power_up   = v;
      CFG_RESET_NIBBLE_WAIT:  cfg_rst_nibble = v;
      CFG_LONG_COMMAND_WAIT:  cfg_long_wait  = v;
      CFG_SHORT_COMMAND_WAIT: cfg_short_wait = v;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [7:0] pu, logic [7:0] rn, logic [7:0] lw, logic [7:0] sw);
    cfg_write(CFG_POWER_UP_WAIT, pu);
    cfg_write(CFG_RESET_NIBBLE_WAIT, rn);
    cfg_write(CFG_LONG_COMMAND_WAIT, lw);
    cfg_write(CFG_SHORT_COMMAND_WAIT, sw);
  endtask

  // Hold off until every launched item has produced its checked result.
  task automatic drain();
    while (pending_items.size() != 0 || item_valid || expected_pins.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    seq_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Short power-up and reset nibble waits so refresh starts early.
    cfg_all(8'd1, 8'd3, 8'd1, 8'd1);

    // Directed: buffer extremes before and during initialization.
    push_item(KIND_WRITE, 0, 8'hFF);
    push_item(KIND_WRITE, 31, 8'h00);
    push_item(KIND_WRITE, 15, 8'hA5);
    push_item(KIND_WRITE, 16, 8'h5A);
    push_item(KIND_TICK, 0, 0);
    push_item(KIND_TICK, 31, 8'hFF);
    push_item(KIND_WRITE, 1, 8'h0F);
    push_item(KIND_WRITE, 30, 8'hF0);
    for (int i = 0; i < 12; i++) push_item(KIND_TICK, i, 8'h55 ^ i);
    push_item(KIND_WRITE, 0, 8'hFF);
    push_item(KIND_WRITE, 2, 8'h80);
    push_item(KIND_TICK, 21, 8'h3C);
    push_item(KIND_WRITE, 14, 8'h7E);
    push_item(KIND_TICK, 10, 8'hC3);
    push_random(150, 12);
    drain();

    // Upper extremes, with a zero short wait.
    cfg_all(8'd255, 8'd255, 8'd255, 8'd0);
    push_random(280, 10);
    drain();

    // Long per-character wait.
    cfg_all(8'd35, 8'd5, 8'd0, 8'd255);
    push_random(80, 15);
    drain();

    // Small random waits; the first stretch runs with no idling on either side.
    cfg_all(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
            8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
    gap_pct  = 0;
    hold_pct = 0;
    push_random(170, 15);
    while (pending_items.size() > 90) @(posedge clk);
    gap_pct  = 27;
    hold_pct = 27;
    drain();

    // Let any stray result show up before the verdict.
    repeat (40) @(posedge clk);

    $display("Ran %0d ticks and %0d buffer writes through init and refresh",
             n_ticks, n_writes);
    $display("Checked %0d pin results across four wait settings, %0d mismatches",
             n_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
